[src/clpwg_pkg.sv]
// ----------------------------------------------------------------------------
// clpwg_pkg: shared types and constants of the chained LED PWM word generator
// Field widths, command codes, sequencer states and the structs that pass
// between the sequencer, the duty memory and the top level.
// ----------------------------------------------------------------------------
package clpwg_pkg;

   // Default number of chained driver chips that the duty memory can hold.
   localparam int MAX_CHIPS_DEF     = 8;
   // Every driver chip has sixteen outputs, so one word holds sixteen bits.
   localparam int CHANNELS_PER_CHIP = 16;
   localparam int CH_W              = $clog2(CHANNELS_PER_CHIP);
   localparam int WORD_W            = CHANNELS_PER_CHIP;
   localparam int DUTY_W            = 8;
   localparam int CHANNEL_W         = 7;
   localparam int COUNT_W           = 4;

   typedef enum logic [1:0] {
      CMD_WRITE     = 2'd0,
      CMD_WRITE_ALL = 2'd1,
      CMD_READ      = 2'd2,
      CMD_NEXT_WORD = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic [WORD_W-1:0] shift_word;
      logic              latch_before;
      logic [DUTY_W-1:0] read_value;
   } result_type;

endpackage

[src/chained_led_pwm_word_generator_top.sv]
// ----------------------------------------------------------------------------
// chained_led_pwm_word_generator_top: PWM shift words for chained LED drivers
// Holds the duty of every LED channel and produces the 16-bit compare words
// that a chain of 16-channel shift-register drivers takes for software PWM.
// ----------------------------------------------------------------------------
//
// The block takes one command item at a time and returns exactly one result
// item for it. The duty memory has a single read port: a shift word needs
// the sixteen duties of one chip, read one per cycle and compared with the
// PWM position as they arrive, and the fill sweep writes one duty per cycle.
// A finished result sits in the output register, so the next item is
// accepted while it waits; the block stalls only when a second result is
// ready and the first has not been taken. Chips are sent from 0 up; the first
// word of every frame carries the latch flag, and after the last chip the PWM
// position steps by one. Duties read as zero after reset; no clearing pass is
// needed. A write of chip_count restarts the frame and keeps the duties; 0 is
// taken as 1 and values above MAX_CHIPS saturate.
//
module chained_led_pwm_word_generator_top #(
   parameter int MAX_CHIPS = clpwg_pkg::MAX_CHIPS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // channel[6:0], duty_value[14:7], zero pad[15]
   input  logic [1:0]  req_tuser,   // command[1:0]

   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // shift_word[15:0], read_value[23:16]
   output logic [0:0]  rsp_tuser,   // latch_before[0]

   // Configuration: chip_count.
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   localparam int ROW_W   = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int ADDR_W  = ROW_W + clpwg_pkg::CH_W;
   localparam int COUNT_W = clpwg_pkg::COUNT_W;

   // Chip count register with saturation of the written value.
   logic [COUNT_W-1:0] chip_count_ff, chip_count_in;

   always_comb begin
      chip_count_in = chip_count_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            chip_count_in = COUNT_W'(1);
         end else if (csr_wdata > COUNT_W'(MAX_CHIPS)) begin
            chip_count_in = COUNT_W'(MAX_CHIPS);
         end else begin
            chip_count_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_count_ff <= COUNT_W'(1);
      end else begin
         chip_count_ff <= chip_count_in;
      end
   end

   // Sequencer and duty memory.
   clpwg_pkg::mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [clpwg_pkg::DUTY_W-1:0]  mem_wr_data;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic [clpwg_pkg::DUTY_W-1:0]  mem_rd_data;
   clpwg_pkg::result_type         result;
   logic                          done;
   logic                          out_free;

   // Output register. It separates the sequencer from the result channel, so
   // a waiting result does not hold up acceptance of the next command.
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0] rsp_tdata_ff, rsp_tdata_in;
   logic [0:0]  rsp_tuser_ff, rsp_tuser_in;

   // The output register can take a new result when it is empty or is being
   // emptied in this cycle.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   clpwg_seq #(
      .MAX_CHIPS (MAX_CHIPS),
      .ROW_W     (ROW_W),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_channel (req_tdata[6:0]),
      .req_duty    (req_tdata[14:7]),
      .chip_count  (chip_count_ff),
      .restart     (csr_we),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   clpwg_duty_mem #(
      .ADDR_W (ADDR_W)
   ) u_duty_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (done) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {result.read_value, result.shift_word};
         rsp_tuser_in  = result.latch_before;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[src/clpwg_duty_mem.sv]
// ----------------------------------------------------------------------------
// clpwg_duty_mem: duty store of the LED PWM word generator
// One write port and one registered read port. A valid bit for each entry,
// cleared by reset, makes an entry that was never written read as zero.
// ----------------------------------------------------------------------------
module clpwg_duty_mem #(
   parameter int ADDR_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  clpwg_pkg::mem_ctl_type        ctl,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [clpwg_pkg::DUTY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [clpwg_pkg::DUTY_W-1:0]  rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [clpwg_pkg::DUTY_W-1:0] store_ff [DEPTH];
   logic [clpwg_pkg::DUTY_W-1:0] rd_q_ff;
   logic [DEPTH-1:0]             valid_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

[src/clpwg_seq.sv]
// ----------------------------------------------------------------------------
// clpwg_seq: command sequencer of the LED PWM word generator
// Runs one command at a time against the duty memory: single writes, the
// fill sweep, reads and the sixteen-read scan that builds a shift word.
// ----------------------------------------------------------------------------
module clpwg_seq #(
   parameter int MAX_CHIPS = clpwg_pkg::MAX_CHIPS_DEF,
   parameter int ROW_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1,
   parameter int ADDR_W    = ROW_W + clpwg_pkg::CH_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [clpwg_pkg::CHANNEL_W-1:0] req_channel,
   input  logic [clpwg_pkg::DUTY_W-1:0]    req_duty,
   input  logic [clpwg_pkg::COUNT_W-1:0]   chip_count,
   input  logic                            restart,
   input  logic                            out_free,
   output logic                            done,
   output clpwg_pkg::result_type           result,
   output clpwg_pkg::mem_ctl_type          mem_ctl,
   output logic [ADDR_W-1:0]               mem_wr_addr,
   output logic [clpwg_pkg::DUTY_W-1:0]    mem_wr_data,
   output logic [ADDR_W-1:0]               mem_rd_addr,
   input  logic [clpwg_pkg::DUTY_W-1:0]    mem_rd_data
);

   localparam int CH_W    = clpwg_pkg::CH_W;
   localparam int COUNT_W = clpwg_pkg::COUNT_W;

   clpwg_pkg::state_type state_ff, state_in;
   clpwg_pkg::cmd_type   cmd;

   logic [ADDR_W-1:0]             fill_ff, fill_in;
   logic [CH_W:0]                 iss_ff, iss_in;
   logic                          cap_vld_ff, cap_vld_in;
   logic [CH_W-1:0]               cap_idx_ff, cap_idx_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [clpwg_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic [clpwg_pkg::WORD_W-1:0]  word_ff, word_in;
   logic                          latch_ff, latch_in;
   logic [clpwg_pkg::DUTY_W-1:0]  readv_ff, readv_in;
   logic [ROW_W-1:0]              chip_index_ff, chip_index_in;
   logic [7:0]                    pos_ff, pos_in;

   logic               accept;
   logic               in_range;
   logic               scan_issue;
   logic               scan_last;
   logic [ADDR_W-1:0]  fill_last;
   logic [ADDR_W-1:0]  chan_addr;
   logic [COUNT_W-1:0] index_next;

   assign cmd        = clpwg_pkg::cmd_type'(req_command);
   assign accept     = (state_ff == clpwg_pkg::ST_IDLE) && req_valid;
   assign in_range   = ({1'b0, req_channel[clpwg_pkg::CHANNEL_W-1:CH_W]} < chip_count);
   assign chan_addr  = ADDR_W'(req_channel);
   assign fill_last  = {ROW_W'(chip_count - COUNT_W'(1)), {CH_W{1'b1}}};
   assign scan_issue = (state_ff == clpwg_pkg::ST_SCAN) && !iss_ff[CH_W];
   assign scan_last  = (state_ff == clpwg_pkg::ST_SCAN) && iss_ff[CH_W];
   assign index_next = COUNT_W'(chip_index_ff) + COUNT_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clpwg_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (cmd)
                  clpwg_pkg::CMD_WRITE:     state_in = clpwg_pkg::ST_FINISH;
                  clpwg_pkg::CMD_WRITE_ALL: state_in = clpwg_pkg::ST_FILL;
                  clpwg_pkg::CMD_READ: begin
                     state_in = in_range ? clpwg_pkg::ST_READ : clpwg_pkg::ST_FINISH;
                  end
                  default:                  state_in = clpwg_pkg::ST_SCAN;
               endcase
            end
         end
         clpwg_pkg::ST_FILL: begin
            if (fill_ff == fill_last) begin
               state_in = clpwg_pkg::ST_FINISH;
            end
         end
         clpwg_pkg::ST_READ: state_in = clpwg_pkg::ST_FINISH;
         clpwg_pkg::ST_SCAN: begin
            if (iss_ff[CH_W]) begin
               state_in = clpwg_pkg::ST_FINISH;
            end
         end
         clpwg_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = clpwg_pkg::ST_IDLE;
            end
         end
         default: state_in = clpwg_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine: handshake and memory port control.
   always_comb begin
      req_ready     = 1'b0;
      done          = 1'b0;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_wr_addr   = chan_addr;
      mem_wr_data   = req_duty;
      mem_rd_addr   = chan_addr;
      case (state_ff)
         clpwg_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            mem_ctl.wr_en = req_valid && (cmd == clpwg_pkg::CMD_WRITE) && in_range;
            mem_ctl.rd_en = req_valid && (cmd == clpwg_pkg::CMD_READ) && in_range;
         end
         clpwg_pkg::ST_FILL: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = fill_ff;
            mem_wr_data   = duty_ff;
         end
         clpwg_pkg::ST_SCAN: begin
            mem_ctl.rd_en = !iss_ff[CH_W];
            mem_rd_addr   = {row_ff, iss_ff[CH_W-1:0]};
         end
         clpwg_pkg::ST_FINISH: begin
            done = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      fill_in       = fill_ff;
      iss_in        = iss_ff;
      cap_vld_in    = scan_issue;
      cap_idx_in    = iss_ff[CH_W-1:0];
      row_in        = row_ff;
      duty_in       = duty_ff;
      word_in       = word_ff;
      latch_in      = latch_ff;
      readv_in      = readv_ff;
      chip_index_in = chip_index_ff;
      pos_in        = pos_ff;

      if (accept) begin
         word_in  = '0;
         latch_in = 1'b0;
         readv_in = '0;
         duty_in  = req_duty;
         fill_in  = '0;
         iss_in   = '0;
         if (cmd == clpwg_pkg::CMD_NEXT_WORD) begin
            // Chip c of the frame takes the channels of row count-1-c.
            row_in   = ROW_W'(chip_count - COUNT_W'(1) - COUNT_W'(chip_index_ff));
            latch_in = (chip_index_ff == '0);
         end
      end

      if (state_ff == clpwg_pkg::ST_FILL) begin
         fill_in = fill_ff + ADDR_W'(1);
      end
      if (state_ff == clpwg_pkg::ST_READ) begin
         readv_in = mem_rd_data;
      end
      if (scan_issue) begin
         iss_in = iss_ff + (CH_W + 1)'(1);
      end
      // The highest channel of the row lands in bit 0 of the word.
      if (cap_vld_ff) begin
         word_in[~cap_idx_ff] = (pos_ff < mem_rd_data);
      end
      if (scan_last) begin
         if (index_next == chip_count) begin
            chip_index_in = '0;
            pos_in        = pos_ff + 8'd1;
         end else begin
            chip_index_in = ROW_W'(index_next);
         end
      end
      if (restart) begin
         chip_index_in = '0;
         pos_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clpwg_pkg::ST_IDLE;
         cap_vld_ff    <= 1'b0;
         chip_index_ff <= '0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         cap_vld_ff    <= cap_vld_in;
         chip_index_ff <= chip_index_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      iss_ff     <= iss_in;
      cap_idx_ff <= cap_idx_in;
      row_ff     <= row_in;
      duty_ff    <= duty_in;
      word_ff    <= word_in;
      latch_ff   <= latch_in;
      readv_ff   <= readv_in;
   end

   assign result.shift_word   = word_ff;
   assign result.latch_before = latch_ff;
   assign result.read_value   = readv_ff;

endmodule

[src/clpwg_checker.sv]
// ----------------------------------------------------------------------------
// clpwg_checker: port-level checks of the LED PWM word generator
// Watches the result channel and reset behavior at the top level's ports.
// ----------------------------------------------------------------------------
module clpwg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A result that is not taken stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // A result item is either a shift word or a read value, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] == 16'd0) || (rsp_tdata[23:16] == 8'd0))
      else $error("shift word and read value both nonzero");

   // The latch flag only comes with a shift word, so the read value is zero.
   a_latch_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:16] == 8'd0)
      else $error("latch flag on a read result");

   // Reset leaves no result offered.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind chained_led_pwm_word_generator_top clpwg_checker u_clpwg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
